/* rtl/npip_pkg.sv */
`default_nettype none

package npip_pkg;

    localparam int DIST_W = 20;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DIST_W-1:0] INIT_DIST = 20'd999999;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    localparam logic [APB_AW-1:0] ADDR_COLOR_DEPTH = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_IMAGE_WIDTH = 3'h4;

    localparam logic [1:0] DEPTH_1BIT = 2'd0;
    localparam logic [1:0] DEPTH_4BIT = 2'd1;
    localparam logic [1:0] DEPTH_8BIT = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_done;
        logic       burst_last;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/nearest_palette_index_packer_top.sv */
// Nearest-palette index packer.
// Input beats on s_valid/s_ready carry either a palette entry (opcode 0) or a
// pixel (opcode 1). A palette write is accepted while idle and gives no output.
// A pixel is compared against the first 2, 16 or 256 palette entries, as
// color_depth selects, one entry per cycle read from the palette RAM. The
// search reads the entries in turn; the read data is then squared, compared
// against the best distance so far, and the winning index is packed. A pixel
// that completes no byte returns to idle after packing and lets the next item
// in; the block takes no new item before it is through with the last one.
// Indices are packed MSB-first into bytes; each completed byte, and at the end
// of a row the flushed byte and up to three zero padding bytes, leave on
// m_valid/m_ready, one beat per cycle while m_ready is high. burst_last marks
// the final beat caused by a pixel and row_done the final beat of a row.
// While output beats are pending or being stalled by the receiver, s_ready is
// low; the block takes the next item only once the last beat is accepted.
// Reset clears the row position, packing state and registers (color_depth 2,
// image_width 1); palette contents stay undefined until written. The user
// writes registers over the APB port only while idle, unchecked by the block.
`default_nettype none

module nearest_palette_index_packer_top
    import npip_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > 13) ? CW : 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT,
        ST_PACK,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [1:0]    color_depth_reg;
    logic [12:0]   image_width_reg;

    logic [23:0]   palette_mem [PALETTE_DEPTH];
    logic [23:0]   rd_data_reg;
    logic          mem_we;

    logic [7:0]    pix_r_reg, pix_g_reg, pix_b_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] last_addr_reg;
    logic [3:0]    bits_reg;

    logic          v1_reg, l1_reg;
    logic [AW-1:0] idx1_reg;
    logic          v2_reg, l2_reg;
    logic [AW-1:0] idx2_reg;
    logic [15:0]   sq_r_reg, sq_g_reg, sq_b_reg;

    logic [AW-1:0]     best_reg;
    logic [DIST_W-1:0] best_dist_reg;

    logic [CW-1:0] col_reg;
    logic [7:0]    acc_reg;
    logic [2:0]    fill_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    pad_left_reg;
    logic          m_valid_reg;
    out_item_t     m_data_reg;

    logic          s_fire, m_fire, cfg_wr;
    logic [8:0]    count_sel;
    logic [3:0]    bits_sel;
    logic [7:0]    d_r, d_g, d_b;
    logic [17:0]   dist_sum;
    logic [7:0]    idx8;
    logic [3:0]    total;
    logic [3:0]    fill_new;
    logic [7:0]    acc_new;
    logic [CW-1:0] col_inc;
    logic [WW-1:0] width_eff;
    logic          row_end;
    logic          emit_byte;
    logic [1:0]    pads;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_fire  = m_valid_reg && m_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            ADDR_COLOR_DEPTH: prdata = APB_DW'(color_depth_reg);
            ADDR_IMAGE_WIDTH: prdata = APB_DW'(image_width_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        case (color_depth_reg)
            DEPTH_1BIT: begin
                bits_sel  = 4'd1;
                count_sel = 9'd2;
            end
            DEPTH_4BIT: begin
                bits_sel  = 4'd4;
                count_sel = 9'd16;
            end
            default: begin
                bits_sel  = 4'd8;
                count_sel = 9'd256;
            end
        endcase
        if (32'(count_sel) > PALETTE_DEPTH) begin
            count_sel = 9'(PALETTE_DEPTH);
        end
    end

    assign mem_we = s_fire && (s_data.opcode == OP_PALETTE)
                    && (32'(s_data.entry_index) < PALETTE_DEPTH);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            palette_mem[s_data.entry_index[AW-1:0]] <= {s_data.red, s_data.green, s_data.blue};
        end
        rd_data_reg <= palette_mem[rd_addr_reg];
    end

    always_comb begin
        d_r = (rd_data_reg[23:16] > pix_r_reg) ? rd_data_reg[23:16] - pix_r_reg
                                               : pix_r_reg - rd_data_reg[23:16];
        d_g = (rd_data_reg[15:8] > pix_g_reg) ? rd_data_reg[15:8] - pix_g_reg
                                              : pix_g_reg - rd_data_reg[15:8];
        d_b = (rd_data_reg[7:0] > pix_b_reg) ? rd_data_reg[7:0] - pix_b_reg
                                             : pix_b_reg - rd_data_reg[7:0];
        dist_sum = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
    end

    always_comb begin
        idx8     = 8'(best_reg) & 8'((9'd1 << bits_reg) - 9'd1);
        total    = {1'b0, fill_reg} + bits_reg;
        fill_new = (total >= 4'd8) ? 4'd8 : total;
        if (total <= 4'd8) begin
            acc_new = acc_reg | 8'(idx8 << (4'd8 - total));
        end else begin
            acc_new = acc_reg | (idx8 >> (total - 4'd8));
        end
        col_inc = col_reg + CW'(1);
        if (image_width_reg == 13'd0) begin
            width_eff = WW'(1);
        end else if (WW'(image_width_reg) > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(image_width_reg);
        end
        row_end   = WW'(col_inc) >= width_eff;
        emit_byte = (fill_new == 4'd8) || (row_end && (fill_new != 4'd0));
        pads      = row_end ? ~phase_reg : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_depth_reg <= DEPTH_8BIT;
            image_width_reg <= 13'd1;
        end else if (cfg_wr) begin
            if (paddr == ADDR_COLOR_DEPTH) begin
                color_depth_reg <= pwdata[1:0];
            end else if (paddr == ADDR_IMAGE_WIDTH) begin
                image_width_reg <= pwdata[12:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= rd_addr_reg;
        l1_reg   <= (rd_addr_reg == last_addr_reg);
        idx2_reg <= idx1_reg;
        l2_reg   <= l1_reg;
        sq_r_reg <= d_r * d_r;
        sq_g_reg <= d_g * d_g;
        sq_b_reg <= d_b * d_b;
        if (s_fire) begin
            pix_r_reg     <= s_data.red;
            pix_g_reg     <= s_data.green;
            pix_b_reg     <= s_data.blue;
            bits_reg      <= bits_sel;
            last_addr_reg <= AW'(count_sel - 9'd1);
            best_reg      <= '0;
            best_dist_reg <= INIT_DIST;
        end else if (v2_reg && (DIST_W'(dist_sum) < best_dist_reg)) begin
            best_reg      <= idx2_reg;
            best_dist_reg <= DIST_W'(dist_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_addr_reg  <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            col_reg      <= '0;
            acc_reg      <= '0;
            fill_reg     <= '0;
            phase_reg    <= '0;
            pad_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_SEARCH);
            v2_reg <= v1_reg;
            case (state_reg)
                ST_IDLE: begin
                    rd_addr_reg <= '0;
                    if (s_fire && (s_data.opcode == OP_PIXEL)) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (rd_addr_reg == last_addr_reg) begin
                        state_reg <= ST_WAIT;
                    end else begin
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                    end
                end
                ST_WAIT: begin
                    if (v2_reg && l2_reg) begin
                        state_reg <= ST_PACK;
                    end
                end
                ST_PACK: begin
                    col_reg <= row_end ? '0 : col_inc;
                    if (emit_byte) begin
                        acc_reg                <= '0;
                        fill_reg               <= '0;
                        phase_reg              <= row_end ? 2'd0 : phase_reg + 2'd1;
                        pad_left_reg           <= pads;
                        m_valid_reg            <= 1'b1;
                        m_data_reg.packed_byte <= acc_new;
                        m_data_reg.row_done    <= row_end && (pads == 2'd0);
                        m_data_reg.burst_last  <= (pads == 2'd0);
                        state_reg              <= ST_EMIT;
                    end else begin
                        acc_reg   <= acc_new;
                        fill_reg  <= fill_new[2:0];
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (m_fire) begin
                        if (pad_left_reg != 2'd0) begin
                            pad_left_reg           <= pad_left_reg - 2'd1;
                            m_data_reg.packed_byte <= 8'd0;
                            m_data_reg.row_done    <= (pad_left_reg == 2'd1);
                            m_data_reg.burst_last  <= (pad_left_reg == 2'd1);
                        end else begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/npip_checker.sv */
`default_nettype none

module npip_checker
    import npip_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A stalled output beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("output beat changed while stalled");

    // The last beat of a row is always the last beat of its burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.row_done |-> m_data.burst_last)
    else $error("row_done without burst_last");

    // No input is taken while output beats are pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
    else $error("input accepted while output pending");

    // A palette write produces no output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_PALETTE) |=> !m_valid)
    else $error("palette write produced output");

endmodule

bind nearest_palette_index_packer_top npip_checker u_npip_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
